>>> rtl/midpoint_circle_point_generator_top_macros.svh
// Assertion macros for the midpoint circle point generator checker.
// Needs nothing else; included by the checker file.
`ifndef MIDPOINT_CIRCLE_POINT_GENERATOR_TOP_MACROS_SVH
`define MIDPOINT_CIRCLE_POINT_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mcpg_pkg.sv
// Shared types, constants and the point-order function of the circle generator.
// No dependencies.
package mcpg_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Eight points per step, indexed 0 to 7.
    localparam logic [2:0] LAST_PT = 3'd7;

    typedef struct packed {
        logic swap;   // offset along x uses the octant y and vice versa
        logic x_neg;  // subtract the x offset from the centre column
        logic y_neg;  // subtract the y offset from the centre row
    } t_pt_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Order: (+x,-y) (+x,+y) (-x,-y) (-x,+y) (+y,-x) (+y,+x) (-y,-x) (-y,+x)
    function automatic t_pt_ctl point_ctl(input logic [2:0] k);
        t_pt_ctl c;
        c.swap  = k[2];
        c.x_neg = k[1];
        c.y_neg = ~k[0];
        return c;
    endfunction

endpackage

>>> rtl/mcpg_front.sv
// Front end: takes input items, holds the octant state and computes one step.
// Depends on mcpg_pkg.
module mcpg_front #(
    parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_start,
    input  logic [COORD_BITS-1:0]  i_cx,
    input  logic [COORD_BITS-1:0]  i_cy,
    input  logic [RADIUS_BITS-1:0] i_radius,
    output logic                   o_push,
    output logic [COORD_BITS-1:0]  o_cx,
    output logic [COORD_BITS-1:0]  o_cy,
    output logic [RADIUS_BITS-1:0] o_x,
    output logic [RADIUS_BITS-1:0] o_y,
    output logic                   o_done
);
    import mcpg_pkg::*;

    localparam int XW = RADIUS_BITS + 2;
    localparam int EW = RADIUS_BITS + 4;
    localparam logic signed [XW-1:0] ONE_X = XW'(1);
    localparam logic signed [XW-1:0] TWO_X = XW'(2);
    localparam logic signed [EW-1:0] ONE_E = EW'(1);

    logic [COORD_BITS-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic signed [XW-1:0]   r_diam, n_diam, r_x, n_x, r_y, n_y, r_xi, n_xi, r_yi, n_yi;
    logic signed [EW-1:0]   r_err, n_err;
    logic                   r_active, n_active;

    logic [COORD_BITS-1:0]  l_cx, l_cy;
    logic signed [XW-1:0]   l_diam, l_x, l_y, l_xi, l_yi, s_x, s_y, s_xi, s_yi;
    logic signed [EW-1:0]   l_err, s_err;
    logic                   l_active, emit, done;

    always_comb begin
        // State seen by this item: freshly loaded on a start, else as stored.
        if (i_start) begin
            l_cx   = i_cx;
            l_cy   = i_cy;
            l_diam = $signed({1'b0, i_radius, 1'b0});
            l_x    = $signed({2'b00, i_radius}) - ONE_X;
            l_y    = '0;
            l_xi   = ONE_X;
            l_yi   = ONE_X;
            l_err  = ONE_E - EW'(l_diam);
        end else begin
            l_cx   = r_cx;
            l_cy   = r_cy;
            l_diam = r_diam;
            l_x    = r_x;
            l_y    = r_y;
            l_xi   = r_xi;
            l_yi   = r_yi;
            l_err  = r_err;
        end
        l_active = i_start | r_active;
        emit     = l_active && (l_x >= l_y);

        s_x   = l_x;
        s_y   = l_y;
        s_xi  = l_xi;
        s_yi  = l_yi;
        s_err = l_err;
        if (s_err <= 0) begin
            s_y   = l_y + ONE_X;
            s_err = l_err + EW'(l_yi);
            s_yi  = l_yi + TWO_X;
        end
        if (s_err > 0) begin
            s_x   = l_x - ONE_X;
            s_xi  = l_xi + TWO_X;
            s_err = s_err + EW'(s_xi) - EW'(l_diam);
        end
        done = s_x < s_y;

        n_cx     = r_cx;
        n_cy     = r_cy;
        n_diam   = r_diam;
        n_x      = r_x;
        n_y      = r_y;
        n_xi     = r_xi;
        n_yi     = r_yi;
        n_err    = r_err;
        n_active = r_active;
        if (i_accept) begin
            n_cx     = l_cx;
            n_cy     = l_cy;
            n_diam   = l_diam;
            n_x      = emit ? s_x : l_x;
            n_y      = emit ? s_y : l_y;
            n_xi     = emit ? s_xi : l_xi;
            n_yi     = emit ? s_yi : l_yi;
            n_err    = emit ? s_err : l_err;
            n_active = emit && !done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_diam   <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_xi     <= ONE_X;
            r_yi     <= ONE_X;
            r_err    <= '0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_diam   <= n_diam;
            r_x      <= n_x;
            r_y      <= n_y;
            r_xi     <= n_xi;
            r_yi     <= n_yi;
            r_err    <= n_err;
            r_active <= n_active;
        end
    end

    // While a step is emitted 0 <= y <= x < radius, so the low bits carry it.
    assign o_push = i_accept && emit;
    assign o_cx   = l_cx;
    assign o_cy   = l_cy;
    assign o_x    = l_x[RADIUS_BITS-1:0];
    assign o_y    = l_y[RADIUS_BITS-1:0];
    assign o_done = done;

endmodule

>>> rtl/mcpg_fifo.sv
// Short register queue of step records between the front and back ends.
// Depends on mcpg_pkg for the status struct.
module mcpg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mcpg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output mcpg_pkg::t_fifo_stat o_stat
);
    import mcpg_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [AW:0]      r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = r_cnt == (AW+1)'(DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/mcpg_back.sv
// Back end: turns one step record into eight symmetric points, one per cycle while the output is not stalled.
// Depends on mcpg_pkg.
module mcpg_back #(
    parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  logic [COORD_BITS-1:0]   i_cx,
    input  logic [COORD_BITS-1:0]   i_cy,
    input  logic [RADIUS_BITS-1:0]  i_x,
    input  logic [RADIUS_BITS-1:0]  i_y,
    input  logic                    i_done,
    output logic                    o_pop,
    input  logic                    i_ready,
    output logic                    o_valid,
    output logic [COORD_BITS+1:0]   o_px,
    output logic [COORD_BITS+1:0]   o_py,
    output logic                    o_last,
    output logic                    o_circle_done
);
    import mcpg_pkg::*;

    localparam int OW = COORD_BITS + 2;
    localparam int SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

    logic [2:0]    r_idx, n_idx;
    logic          r_valid, n_valid;
    logic [OW-1:0] r_px, r_py;
    logic          r_last, r_done;

    t_pt_ctl          ctl;
    logic             load;
    logic [SW-1:0]    off_a, off_b, cx_w, cy_w, px_w, py_w;

    always_comb begin
        ctl   = point_ctl(r_idx);
        off_a = SW'(ctl.swap ? i_y : i_x);
        off_b = SW'(ctl.swap ? i_x : i_y);
        cx_w  = SW'(i_cx);
        cy_w  = SW'(i_cy);
        px_w  = ctl.x_neg ? cx_w - off_a : cx_w + off_a;
        py_w  = ctl.y_neg ? cy_w - off_b : cy_w + off_b;

        load    = !i_empty && (!r_valid || i_ready);
        n_idx   = load ? r_idx + 3'd1 : r_idx;
        n_valid = load ? 1'b1 : (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= px_w[OW-1:0];
            r_py   <= py_w[OW-1:0];
            r_last <= r_idx == LAST_PT;
            r_done <= (r_idx == LAST_PT) && i_done;
        end
    end

    assign o_pop         = load && (r_idx == LAST_PT);
    assign o_valid       = r_valid;
    assign o_px          = r_px;
    assign o_py          = r_py;
    assign o_last        = r_last;
    assign o_circle_done = r_done;

endmodule

>>> rtl/midpoint_circle_point_generator_top.sv
// Path: the front end computes a step as the input transaction is accepted and writes it
// into the step queue, from which the output register loads the first point.
// Eight point transactions per step go out at one per cycle through the single output
// register while m_axis_tready is high; inputs are taken while the queue has room, and
// an input that draws nothing writes no record.
// Reset (i_rst_n, synchronous, active low) drops any circle, empties the queue and output.
module midpoint_circle_point_generator_top #(
    parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF,
    parameter int QUEUE_DEPTH = mcpg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_x, center_y, radius, zero padding
    input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // start_req
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // point_x, point_y, zero padding
    output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast,
    // circle_done
    output logic m_axis_tuser
);
    import mcpg_pkg::*;

    localparam int OUT_TW = ((2*(COORD_BITS+2)+7)/8)*8;
    localparam int REC_W  = 2*COORD_BITS + 2*RADIUS_BITS + 1;

    logic                   in_accept, push, pop, f_done;
    logic [COORD_BITS-1:0]  f_cx, f_cy, b_cx, b_cy;
    logic [RADIUS_BITS-1:0] f_x, f_y, b_x, b_y;
    logic                   b_done;
    logic [REC_W-1:0]       q_in, q_out;
    t_fifo_stat             q_stat;
    logic [COORD_BITS+1:0]  px, py;

    assign s_axis_tready = !q_stat.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mcpg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_start  (s_axis_tuser),
        .i_cx     (s_axis_tdata[COORD_BITS-1:0]),
        .i_cy     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_radius (s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
        .o_push   (push),
        .o_cx     (f_cx),
        .o_cy     (f_cy),
        .o_x      (f_x),
        .o_y      (f_y),
        .o_done   (f_done)
    );

    assign q_in = {f_done, f_y, f_x, f_cy, f_cx};

    mcpg_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    assign {b_done, b_y, b_x, b_cy, b_cx} = q_out;

    mcpg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_stat.empty),
        .i_cx          (b_cx),
        .i_cy          (b_cy),
        .i_x           (b_x),
        .i_y           (b_y),
        .i_done        (b_done),
        .o_pop         (pop),
        .i_ready       (m_axis_tready),
        .o_valid       (m_axis_tvalid),
        .o_px          (px),
        .o_py          (py),
        .o_last        (m_axis_tlast),
        .o_circle_done (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TW'({py, px});

endmodule

>>> rtl/mcpg_checker.sv
// Port-level checker for the circle point generator, bound to the top level.
// Depends on mcpg_pkg and midpoint_circle_point_generator_top_macros.svh.
`include "midpoint_circle_point_generator_top_macros.svh"

module mcpg_checker #(
    parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    input logic m_axis_tlast,
    input logic m_axis_tuser
);
    import mcpg_pkg::*;

    // A stalled point must stay valid and unchanged.
    `MCPG_ASSERT_NEXT(a_out_hold_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped while stalled")
    `MCPG_ASSERT_NEXT(a_out_hold_data, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output payload changed while stalled")

    // The end of a circle is only ever flagged on the eighth point of a step.
    `MCPG_ASSERT_SAME(a_done_on_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "circle_done without tlast")

    // Leaving reset, the output register is empty and the queue has room.
    `MCPG_ASSERT_SAME(a_reset_out_idle, i_clk, i_rst_n, !$past(i_rst_n), !m_axis_tvalid && s_axis_tready, "output not idle after reset")

endmodule

bind midpoint_circle_point_generator_top mcpg_checker #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
) u_mcpg_checker (.*);
